// ----- design/brmx_pkg.sv -----
// Shared types and constants for the byte-wise modular exponentiation core.
`default_nettype none

package brmx_pkg;

    // Configuration port geometry
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_EXP = 2'd2;

    // Operation kinds
    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    // Input beat
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       last_in;
    } in_beat_t;

    // Output beat
    typedef struct packed {
        logic [7:0] result_byte;
        logic       last_out;
    } out_beat_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture input beat, select exponent, acc = 1
        logic start_base;  // start reduction of the input byte
        logic take_base;   // store reduced base
        logic start_bit;   // start square (and multiply when bit set)
        logic take_bit;    // store square/product, shift exponent
        logic emit;        // load output register
    } brmx_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic exp_zero;       // selected exponent is zero
        logic exp_rest_zero;  // no set bits above the current one
        logic mul_done;       // multiplier units finished
    } brmx_status_t;

endpackage

`default_nettype wire

// ----- design/brmx_mulmod.sv -----
// Bit-serial interleaved modular multiplier: r = a * b mod m, one bit of a per cycle.
`default_nettype none

module brmx_mulmod #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W:0]   m,      // m = 2^W encodes a zero modulus
    output logic              done,
    output logic [W-1:0]      r
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     a_reg, b_reg, r_reg;

    logic [W+1:0] t;
    logic [W+2:0] d1, d2;
    logic [W-1:0] r_step;

    // One step: t = 2r + a_i*b, then reduce (t < 3m)
    always_comb
    begin
        t  = {r_reg, 1'b0} + (a_reg[W-1] ? {2'b00, b_reg} : '0);
        d1 = {1'b0, t} - {2'b00, m};
        d2 = {1'b0, t} - {1'b0, m, 1'b0};
        if (!d2[W+2])
        begin
            r_step = d2[W-1:0];
        end
        else if (!d1[W+2])
        begin
            r_step = d1[W-1:0];
        end
        else
        begin
            r_step = t[W-1:0];
        end
    end

    // Control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg <= {a_reg[W-2:0], 1'b0};
            r_reg <= r_step;
        end
    end

    assign done = done_reg;
    assign r    = r_reg;

endmodule

`default_nettype wire

// ----- design/brmx_datapath.sv -----
// Datapath: key registers, exponent shifter, base/accumulator and two multipliers.
`default_nettype none

module brmx_datapath #(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [brmx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [brmx_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire brmx_pkg::in_beat_t                in_data,
    input  wire brmx_pkg::brmx_cmd_t               cmd,
    output brmx_pkg::brmx_status_t                 status,
    output brmx_pkg::out_beat_t                    out_data
);

    logic [MOD_WIDTH-1:0] modulus_reg;
    logic [EXP_WIDTH-1:0] pub_exp_reg, priv_exp_reg;

    logic [EXP_WIDTH-1:0] exp_reg;
    logic [MOD_WIDTH-1:0] base_reg, acc_reg;
    logic [7:0]           data_reg;
    logic                 last_reg;
    brmx_pkg::out_beat_t  out_data_reg;

    logic [MOD_WIDTH:0]   mod_ext;
    logic [MOD_WIDTH-1:0] sq_a, sq_b, sq_r, mu_r;
    logic                 sq_done, mu_done;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MOD_WIDTH'(1);
            pub_exp_reg  <= '0;
            priv_exp_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                brmx_pkg::REG_MODULUS:     modulus_reg  <= cfg_data[MOD_WIDTH-1:0];
                brmx_pkg::REG_PUBLIC_EXP:  pub_exp_reg  <= cfg_data[EXP_WIDTH-1:0];
                brmx_pkg::REG_PRIVATE_EXP: priv_exp_reg <= cfg_data[EXP_WIDTH-1:0];
                default:                   ;
            endcase
        end
    end

    // Zero modulus means plain wrap at 2^MOD_WIDTH
    assign mod_ext = {(modulus_reg == '0), modulus_reg};

    // Squarer also reduces the input byte (byte * 1 mod m)
    assign sq_a = cmd.start_base ? MOD_WIDTH'(data_reg) : base_reg;
    assign sq_b = cmd.start_base ? MOD_WIDTH'(1) : base_reg;

    brmx_mulmod #(
        .W(MOD_WIDTH)
    ) u_square (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_base | cmd.start_bit),
        .a     (sq_a),
        .b     (sq_b),
        .m     (mod_ext),
        .done  (sq_done),
        .r     (sq_r)
    );

    brmx_mulmod #(
        .W(MOD_WIDTH)
    ) u_mult (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_bit & exp_reg[0]),
        .a     (acc_reg),
        .b     (base_reg),
        .m     (mod_ext),
        .done  (mu_done),
        .r     (mu_r)
    );

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            exp_reg  <= (in_data.kind == brmx_pkg::KIND_DECRYPT) ? priv_exp_reg : pub_exp_reg;
            data_reg <= in_data.data_byte;
            last_reg <= in_data.last_in;
            acc_reg  <= MOD_WIDTH'(1);
        end
        if (cmd.take_base)
        begin
            base_reg <= sq_r;
        end
        if (cmd.take_bit)
        begin
            base_reg <= sq_r;
            exp_reg  <= exp_reg >> 1;
            if (exp_reg[0])
            begin
                acc_reg <= mu_r;
            end
        end
        if (cmd.emit)
        begin
            out_data_reg.result_byte <= acc_reg[7:0];
            out_data_reg.last_out    <= last_reg;
        end
    end

    // Both units run the same length; the squarer always runs
    assign status.exp_zero      = (exp_reg == '0);
    assign status.exp_rest_zero = (exp_reg[EXP_WIDTH-1:1] == '0);
    assign status.mul_done      = sq_done & (mu_done | ~mu_done);

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

// ----- design/brmx_ctrl.sv -----
// Controller: sequences base reduction and one square-and-multiply round per exponent bit.
`default_nettype none

module brmx_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire brmx_pkg::brmx_status_t status,
    output brmx_pkg::brmx_cmd_t         cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASE  = 3'd1;
    localparam logic [2:0] S_BASEW = 3'd2;
    localparam logic [2:0] S_BIT   = 3'd3;
    localparam logic [2:0] S_BITW  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                if (status.exp_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.start_base = 1'b1;
                    state_next     = S_BASEW;
                end
            end
            S_BASEW:
            begin
                if (status.mul_done)
                begin
                    cmd.take_base = 1'b1;
                    state_next    = S_BIT;
                end
            end
            S_BIT:
            begin
                cmd.start_bit = 1'b1;
                state_next    = S_BITW;
            end
            S_BITW:
            begin
                if (status.mul_done)
                begin
                    cmd.take_bit = 1'b1;
                    state_next   = status.exp_rest_zero ? S_OUT : S_BIT;
                end
            end
            S_OUT:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- design/bytewise_rsa_modexp_core.sv -----
// Byte-wise modular exponentiation core (right-to-left square-and-multiply).
// Usage:
//   Write modulus (index 0), public exponent (1) and private exponent (2)
//   through cfg_we/cfg_index/cfg_data while the core is idle.
//   Input beats (kind, data_byte, last_in) arrive on in_valid/in_ready;
//   one output beat (result_byte, last_out) leaves on out_valid/out_ready.
//   kind 0 uses the public exponent, kind 1 the private one.
// Operation:
//   One byte at a time. Each exponent round runs the squarer, and the
//   multiplier beside it when the exponent bit is set, both bit-serial.
//   Rounds run up to the highest set exponent bit; a zero exponent skips
//   them and yields 1 without reduction.
// Reset:
//   Modulus resets to 1, exponents to 0; no output beat is pending.
// Stalls:
//   The finished beat sits in an output register; the next byte is accepted
//   and worked on meanwhile, and waits for that register before it is shown.
//   A zero modulus means plain wrap at 2^MOD_WIDTH.
`default_nettype none

module bytewise_rsa_modexp_core #(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire brmx_pkg::in_beat_t              in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output brmx_pkg::out_beat_t                  out_data,
    input  wire logic                            cfg_we,
    input  wire logic [brmx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [brmx_pkg::CFG_DATA_W-1:0] cfg_data
);

    brmx_pkg::brmx_cmd_t    cmd;
    brmx_pkg::brmx_status_t status;

    // Sequencer
    brmx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and key storage
    brmx_datapath #(
        .MOD_WIDTH(MOD_WIDTH),
        .EXP_WIDTH(EXP_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for the byte-wise modular exponentiation core with its own predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int MOD_W           = 32;
    localparam int EXP_W           = 64;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 32;
    localparam int QUIET_PHASE     = 4;     // no idling on either side
    localparam int PAUSE_PHASE     = 3;     // sender drains the core mid-phase
    localparam int IDLE_PCT        = 28;
    localparam int STALL_LIMIT     = 12000; // cycles with no beat moving
    localparam int END_WAIT        = 2300;  // about one full 64-bit exponent

    // Expected result together with the beat that caused it
    typedef struct {
        brmx_pkg::in_beat_t  src;
        brmx_pkg::out_beat_t want;
    } pending_byte_t;

    // Scoreboard: key registers, predictor and the queue of expected bytes
    class modexp_scoreboard;
        bit [MOD_W-1:0] modulus;
        bit [EXP_W-1:0] pub_exp;
        bit [EXP_W-1:0] priv_exp;
        pending_byte_t  expected_q[$];
        int unsigned    mismatches;

        function new();
            modulus    = MOD_W'(1);
            pub_exp    = '0;
            priv_exp   = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [brmx_pkg::CFG_IDX_W-1:0] idx,
                              bit [brmx_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                brmx_pkg::REG_MODULUS:     modulus  = value[MOD_W-1:0];
                brmx_pkg::REG_PUBLIC_EXP:  pub_exp  = value[EXP_W-1:0];
                brmx_pkg::REG_PRIVATE_EXP: priv_exp = value[EXP_W-1:0];
                default: ;
            endcase
        endfunction

        // Zero modulus means plain wrap at 2^MOD_W
        function bit [63:0] reduce_mod(bit [63:0] v);
            if (modulus == 0)
                return v & ((64'd1 << MOD_W) - 1);
            return v % {{(64-MOD_W){1'b0}}, modulus};
        endfunction

        // Right-to-left square-and-multiply, low byte of the residue
        function bit [7:0] modexp_byte(bit [7:0] base_byte, bit [EXP_W-1:0] expo);
            bit [63:0] acc;
            bit [63:0] sq;
            if (expo == 0)
                return 8'd1;   // zero exponent: 1 without reduction
            acc = 64'd1;
            sq  = reduce_mod({56'd0, base_byte});
            for (int i = 0; i < EXP_W; i++) begin
                if (expo[i])
                    acc = reduce_mod(acc * sq);
                sq = reduce_mod(sq * sq);
            end
            return acc[7:0];
        endfunction

        function void note_input(brmx_pkg::in_beat_t beat);
            pending_byte_t p;
            p.src              = beat;
            p.want.result_byte = modexp_byte(beat.data_byte,
                                             (beat.kind == brmx_pkg::KIND_DECRYPT) ?
                                             priv_exp : pub_exp);
            p.want.last_out    = beat.last_in;
            expected_q.push_back(p);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(brmx_pkg::out_beat_t got);
            pending_byte_t p;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat with nothing expected: byte %02h last %0b",
                                 got.result_byte, got.last_out));
                return;
            end
            p = expected_q.pop_front();
            if (got.result_byte !== p.want.result_byte)
                report($sformatf("kind %0b byte %02h mod %08h: result %02h, expected %02h",
                                 p.src.kind, p.src.data_byte, modulus,
                                 got.result_byte, p.want.result_byte));
            if (got.last_out !== p.want.last_out)
                report($sformatf("byte %02h: last_out %0b, expected %0b",
                                 p.src.data_byte, got.last_out, p.want.last_out));
        endtask
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    brmx_pkg::in_beat_t              in_data   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    brmx_pkg::out_beat_t             out_data;
    logic                            cfg_we    = 1'b0;
    logic [brmx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [brmx_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    bit                              no_gaps = 1'b0;
    int unsigned                     quiet_cycles = 0;
    modexp_scoreboard                sb;

    bytewise_rsa_modexp_core #(
        .MOD_WIDTH (MOD_W),
        .EXP_WIDTH (EXP_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Result side back-pressure
    always @(negedge clk)
        out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);

    // Beat monitor and activity counter for the watchdog
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("bytewise_rsa_modexp_core verification failed");
        $finish;
    end

    // Register write; the extra cycle keeps we low between writes
    task write_reg(logic [brmx_pkg::CFG_IDX_W-1:0] idx,
                   logic [brmx_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task load_key(logic [brmx_pkg::CFG_DATA_W-1:0] mod_word, logic [63:0] e,
                  logic [63:0] d);
        write_reg(brmx_pkg::REG_MODULUS, mod_word);
        write_reg(brmx_pkg::REG_PUBLIC_EXP, e);
        write_reg(brmx_pkg::REG_PRIVATE_EXP, d);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task send_item(logic kind, logic [7:0] data, logic last);
        brmx_pkg::in_beat_t beat;
        beat.kind      = kind;
        beat.data_byte = data;
        beat.last_in   = last;
        while (!no_gaps && ($urandom_range(0, 99) < IDLE_PCT)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task idle_input();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task wait_drained();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic [63:0] rand_exponent(bit full_width);
        logic [63:0] raw;
        int unsigned bits;
        raw = {$urandom, $urandom};
        if (full_width)
            return raw;
        bits = $urandom_range(0, 14);
        return (bits == 0) ? 64'd0 : raw & ((64'd1 << bits) - 1);
    endfunction

    // Junk in the upper half checks that only the low MOD_W bits count
    function automatic logic [63:0] pick_modulus(int phase);
        logic [31:0] m;
        case (phase)
            0:       m = 32'd0;
            1:       m = 32'hFFFF_FFFF;
            default: m = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 1000) : $urandom;
        endcase
        return {$urandom, m};
    endfunction

    initial begin
        sb = new();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset key: modulus 1, zero exponents, so every byte gives 1
        send_item(brmx_pkg::KIND_ENCRYPT, 8'h00, 1'b0);
        send_item(brmx_pkg::KIND_DECRYPT, 8'hFF, 1'b1);
        send_item(brmx_pkg::KIND_ENCRYPT, 8'h80, 1'b0);
        idle_input();
        wait_drained();

        // Zero modulus (plain wrap) with small and all-ones exponents
        load_key({32'hABCD_1234, 32'h0}, 64'd3, '1);
        send_item(brmx_pkg::KIND_ENCRYPT, 8'hFF, 1'b0);
        send_item(brmx_pkg::KIND_DECRYPT, 8'h02, 1'b1);
        send_item(brmx_pkg::KIND_DECRYPT, 8'hFF, 1'b0);
        send_item(brmx_pkg::KIND_ENCRYPT, 8'h00, 1'b1);
        idle_input();
        wait_drained();

        // Largest modulus, exponent one and zero
        load_key({32'h5A5A_5A5A, 32'hFFFF_FFFF}, 64'd1, 64'd0);
        send_item(brmx_pkg::KIND_ENCRYPT, 8'h00, 1'b0);
        send_item(brmx_pkg::KIND_ENCRYPT, 8'hFF, 1'b1);
        send_item(brmx_pkg::KIND_DECRYPT, 8'h4D, 1'b0);
        send_item(brmx_pkg::KIND_ENCRYPT, 8'h01, 1'b0);
        idle_input();
        wait_drained();

        // Modulus one with nonzero exponents reduces everything to zero
        load_key(64'd1, 64'd5, 64'd2);
        send_item(brmx_pkg::KIND_ENCRYPT, 8'hC8, 1'b0);
        send_item(brmx_pkg::KIND_DECRYPT, 8'h03, 1'b1);
        idle_input();
        wait_drained();

        // Textbook key pair n = 61 * 53
        load_key(64'd3233, 64'd17, 64'd2753);
        send_item(brmx_pkg::KIND_ENCRYPT, 8'h41, 1'b0);
        send_item(brmx_pkg::KIND_DECRYPT, 8'hB6, 1'b0);
        send_item(brmx_pkg::KIND_ENCRYPT, 8'hFF, 1'b1);
        send_item(brmx_pkg::KIND_DECRYPT, 8'h00, 1'b0);
        idle_input();
        wait_drained();

        // Random phases, mostly short exponents, a few full-width ones
        for (int p = 0; p < NUM_PHASES; p++) begin
            no_gaps = (p == QUIET_PHASE);
            if (p == NUM_PHASES - 1)
                load_key({$urandom, $urandom}, '1, '1);
            else
                load_key(pick_modulus(p), rand_exponent(p == 2), rand_exponent(p == 5));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) begin
                    idle_input();
                    wait_drained();
                end
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          $urandom_range(0, 7) == 0);
            end
            idle_input();
            wait_drained();
        end
        no_gaps = 1'b0;

        // Let any stray beat show up before the verdict
        repeat (END_WAIT) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("bytewise_rsa_modexp_core verification clean");
        else
            $display("bytewise_rsa_modexp_core verification failed");
        $finish;
    end

endmodule
